### hw/rtl/vtx_pkg.sv
package vtx_pkg;

  localparam int FieldW  = 32;
  localparam int RegW    = 64;
  localparam int NumRegs = 8;
  localparam int CfgIdxW = 8;

  localparam logic OpHomog = 1'b0;
  localparam logic OpPoint = 1'b1;

  // identity at 16 fraction bits
  localparam logic [RegW-1:0] RegReset [NumRegs] = '{
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic               operation;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } vtx_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               divide_fault;
    logic               saturated;
  } vtx_out_t;

endpackage

### hw/rtl/vtx_mat_mul.sv
module vtx_mat_mul #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic                  op_i,
  input  logic signed [CW-1:0]  vec_i  [4],
  input  logic signed [31:0]    coef_i [4][4],
  output logic                  valid_o,
  output logic                  op_o,
  output logic signed [CW-1:0]  res_o  [4],
  output logic                  clip_o
);
  import vtx_pkg::*;

  localparam int VW  = (CW > FB + 1) ? CW : FB + 2;
  localparam int PW  = VW + 32;
  localparam int SW  = PW + 2;
  localparam int SHW = SW - FB;

  logic                 vld_q [3];
  logic                 op_q  [3];
  logic signed [VW-1:0] vec   [4];
  logic signed [PW-1:0] prod_q [4][4];
  logic signed [SW-1:0] sum_q [4];
  logic signed [CW-1:0] res_d [4];
  logic signed [CW-1:0] res_q [4];
  logic [3:0]           ovf;
  logic                 clip_q;

  always_comb begin
    for (int r = 0; r < 3; r++) vec[r] = VW'(vec_i[r]);
    vec[3] = (op_i == OpPoint) ? (VW'(1) <<< FB) : VW'(vec_i[3]);
  end

  // round half up, shift, clip to coordinate width
  always_comb begin
    logic signed [SW-1:0]  rnd;
    logic signed [SHW-1:0] sh;
    for (int c = 0; c < 4; c++) begin
      rnd = sum_q[c] + (SW'(1) <<< (FB - 1));
      sh  = SHW'(rnd >>> FB);
      ovf[c] = (sh[SHW-1:CW-1] != '0) && (sh[SHW-1:CW-1] != '1);
      if (!ovf[c]) res_d[c] = sh[CW-1:0];
      else if (sh[SHW-1]) res_d[c] = {1'b1, {(CW-1){1'b0}}};
      else res_d[c] = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      vld_q[1] <= vld_q[0];
      vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    op_q[0] <= op_i;
    op_q[1] <= op_q[0];
    op_q[2] <= op_q[1];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        prod_q[r][c] <= vec[r] * coef_i[r][c];
    for (int c = 0; c < 4; c++)
      sum_q[c] <= SW'(prod_q[0][c]) + SW'(prod_q[1][c]) + SW'(prod_q[2][c])
                + SW'(prod_q[3][c]);
    res_q  <= res_d;
    clip_q <= |ovf;
  end

  assign valid_o = vld_q[2];
  assign op_o    = op_q[2];
  assign res_o   = res_q;
  assign clip_o  = clip_q;

endmodule

### hw/rtl/vtx_div_pipe.sv
module vtx_div_pipe #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int TW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] num_i [3],
  input  logic signed [CW-1:0] den_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] quo_o [3],
  output logic [2:0]           ovf_o,
  output logic [TW-1:0]        tag_o
);

  localparam int QW = CW + FB;

  logic          vld_q [QW+1];
  logic [TW-1:0] tag_q [QW+1];
  logic [CW-1:0] den_q [QW+1];
  logic [CW-1:0] rem_q [QW+1][3];
  logic [QW-1:0] num_q [QW+1][3];
  logic [QW-1:0] quo_q [QW+1][3];
  logic          neg_q [QW+1][3];

  // entry: magnitudes and quotient sign
  always_ff @(posedge clk_i) begin
    den_q[0] <= den_i[CW-1] ? CW'(-den_i) : den_i;
    tag_q[0] <= tag_i;
    for (int l = 0; l < 3; l++) begin
      rem_q[0][l] <= '0;
      quo_q[0][l] <= '0;
      num_q[0][l] <= {(num_i[l][CW-1] ? CW'(-num_i[l]) : num_i[l]), {FB{1'b0}}};
      neg_q[0][l] <= num_i[l][CW-1] ^ den_i[CW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QW; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 0; s < QW; s++) vld_q[s+1] <= vld_q[s];
    end
  end

  // one restoring step per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      den_q[s+1] <= den_q[s];
      tag_q[s+1] <= tag_q[s];
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW:0] trial;
      logic [CW:0] diff;
      logic        ge;
      assign trial = {rem_q[s][l], num_q[s][l][QW-1]};
      assign diff  = trial - {1'b0, den_q[s]};
      assign ge    = trial >= {1'b0, den_q[s]};
      always_ff @(posedge clk_i) begin
        rem_q[s+1][l] <= ge ? diff[CW-1:0] : trial[CW-1:0];
        num_q[s+1][l] <= {num_q[s][l][QW-2:0], 1'b0};
        quo_q[s+1][l] <= {quo_q[s][l][QW-2:0], ge};
        neg_q[s+1][l] <= neg_q[s][l];
      end
    end
  end

  always_comb begin
    logic [QW-1:0] q;
    for (int l = 0; l < 3; l++) begin
      q = quo_q[QW][l];
      if (neg_q[QW][l]) begin
        ovf_o[l] = q > (QW'(1) << (CW - 1));
        quo_o[l] = ovf_o[l] ? {1'b1, {(CW-1){1'b0}}} : CW'(-q[CW-1:0]);
      end else begin
        ovf_o[l] = q[QW-1:CW-1] != '0;
        quo_o[l] = ovf_o[l] ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign tag_o   = tag_q[QW];

endmodule

### hw/rtl/vertex_transform_4x4.sv
// Vertex transform: row vector times a 4x4 Q-format matrix.
// Command channel: start_i with item_i is taken on any edge where busy_o
// is low; busy_o stays low, so one vertex can enter every cycle.
// Operation homogeneous returns [x y z w]*M; point takes w as one, adds
// row 3 and divides x, y, z by the resulting w (zero w: divide_fault,
// all outputs zero).
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and a 64-bit
// cfg_data_i word; indexes 0..7 select row0_left..row3_right, others are
// dropped. Write only while no vertex is in flight.
// Result: done_o pulses one cycle with result_o. The receiver cannot
// stall, so the pipeline never holds.
// Pipeline: matrix multiply, then the bit-per-stage divider (COORD capped
// at 32), then the output register; throughput one vertex per cycle.
// Reset loads the identity matrix and empties the pipeline.
module vertex_transform_4x4 #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  vtx_pkg::vtx_in_t               item_i,
  output logic                           busy_o,
  output logic                           done_o,
  output vtx_pkg::vtx_out_t              result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vtx_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vtx_pkg::RegW-1:0]       cfg_data_i
);
  import vtx_pkg::*;

  localparam int E   = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int QW  = E + FRAC_BITS;
  localparam int TW  = 3 + 4 * E;
  localparam int Lat = QW + 5;

  logic [RegW-1:0]     regs_q [NumRegs];
  logic signed [31:0]  coef [4][4];
  logic signed [E-1:0] vec  [4];
  logic                accept;

  logic                mm_vld, mm_op, mm_clip;
  logic signed [E-1:0] mm_res [4];
  logic signed [E-1:0] num [3];
  logic                fault;
  logic [TW-1:0]       tag_in, tag_out;

  logic                dv_vld;
  logic signed [E-1:0] dv_quo [3];
  logic [2:0]          dv_ovf;

  logic                t_op, t_fault, t_clip;
  logic signed [E-1:0] t_res [4];

  vtx_out_t result_d, result_q;
  logic     done_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= RegReset[i];
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      regs_q[cfg_index_i[$clog2(NumRegs)-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        coef[r][c] = (c % 2 == 1) ? regs_q[r*2 + c/2][31:0] : regs_q[r*2 + c/2][63:32];
  end

  assign vec[0] = item_i.in_x[E-1:0];
  assign vec[1] = item_i.in_y[E-1:0];
  assign vec[2] = item_i.in_z[E-1:0];
  assign vec[3] = item_i.in_w[E-1:0];

  vtx_mat_mul #(.CW(E), .FB(FRAC_BITS)) u_mat_mul (
    .clk_i, .rst_ni,
    .valid_i (accept),
    .op_i    (item_i.operation),
    .vec_i   (vec),
    .coef_i  (coef),
    .valid_o (mm_vld),
    .op_o    (mm_op),
    .res_o   (mm_res),
    .clip_o  (mm_clip)
  );

  assign fault  = (mm_op == OpPoint) && (mm_res[3] == '0);
  assign num[0] = mm_res[0];
  assign num[1] = mm_res[1];
  assign num[2] = mm_res[2];
  assign tag_in = {mm_op, fault, mm_clip, mm_res[3], mm_res[2], mm_res[1], mm_res[0]};

  vtx_div_pipe #(.CW(E), .FB(FRAC_BITS), .TW(TW)) u_div_pipe (
    .clk_i, .rst_ni,
    .valid_i (mm_vld),
    .num_i   (num),
    .den_i   (mm_res[3]),
    .tag_i   (tag_in),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .tag_o   (tag_out)
  );

  assign t_op     = tag_out[TW-1];
  assign t_fault  = tag_out[TW-2];
  assign t_clip   = tag_out[TW-3];
  assign t_res[3] = tag_out[4*E-1:3*E];
  assign t_res[2] = tag_out[3*E-1:2*E];
  assign t_res[1] = tag_out[2*E-1:E];
  assign t_res[0] = tag_out[E-1:0];

  always_comb begin
    result_d = '0;
    if (t_op == OpHomog) begin
      result_d.out_x     = 32'(t_res[0]);
      result_d.out_y     = 32'(t_res[1]);
      result_d.out_z     = 32'(t_res[2]);
      result_d.out_w     = 32'(t_res[3]);
      result_d.saturated = t_clip;
    end else if (t_fault) begin
      result_d.divide_fault = 1'b1;
    end else begin
      result_d.out_x     = 32'(dv_quo[0]);
      result_d.out_y     = 32'(dv_quo[1]);
      result_d.out_z     = 32'(dv_quo[2]);
      result_d.out_w     = 32'(t_res[3]);
      result_d.saturated = t_clip || (|dv_ovf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Lat done_o)
    else $error("word did not arrive after the pipeline latency");

  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.divide_fault |-> !result_o.saturated && result_o.out_x == '0
      && result_o.out_y == '0 && result_o.out_z == '0 && result_o.out_w == '0)
    else $error("divide fault word not zeroed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result word without a command");
`endif

endmodule

### sim/vertex_transform_4x4_chk.sv
`timescale 1ns / 100ps

module vertex_transform_4x4_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_o,
  input  vtx_pkg::vtx_in_t            item_i,
  input  logic                        done_o,
  input  vtx_pkg::vtx_out_t           result_o,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [vtx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [vtx_pkg::RegW-1:0]    cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import vtx_pkg::*;

  localparam int Frac = 16;
  localparam logic signed [79:0] SatHi = 80'sh7fff_ffff;
  localparam logic signed [79:0] SatLo = -80'sh8000_0000;

  logic [RegW-1:0] matrix_regs [NumRegs];
  vtx_out_t        vertex_q [$];

  function automatic logic signed [31:0] clip32(input logic signed [79:0] v, inout logic clip);
    if (v > SatHi) begin
      clip = 1'b1;
      return SatHi[31:0];
    end
    if (v < SatLo) begin
      clip = 1'b1;
      return SatLo[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] coef(input int row, input int col);
    logic [RegW-1:0] r;
    r = matrix_regs[row*2 + col/2];
    return (col % 2) ? r[31:0] : r[63:32];
  endfunction

  function automatic vtx_out_t transform_vertex(input vtx_in_t v);
    logic signed [79:0] vec [4];
    logic signed [79:0] acc;
    logic signed [31:0] sum [4];
    logic signed [63:0] num;
    logic signed [63:0] quo;
    logic               clip;
    vtx_out_t           r;
    clip = 1'b0;
    vec[0] = v.in_x;
    vec[1] = v.in_y;
    vec[2] = v.in_z;
    vec[3] = (v.operation == OpPoint) ? 80'sd65536 : 80'(v.in_w);
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += vec[k] * 80'(coef(k, c));
      acc = (acc + 80'sd32768) >>> Frac;  // round half up, floor shift
      sum[c] = clip32(acc, clip);
    end
    if (v.operation == OpPoint) begin
      if (sum[3] == 0) begin
        clip = 1'b0;
        for (int c = 0; c < 4; c++) sum[c] = '0;
      end else begin
        for (int c = 0; c < 3; c++) begin
          num = 64'(sum[c]) <<< Frac;
          quo = num / 64'(sum[3]);  // truncates toward zero
          sum[c] = clip32(80'(quo), clip);
        end
      end
    end
    r.out_x = sum[0];
    r.out_y = sum[1];
    r.out_z = sum[2];
    r.out_w = sum[3];
    r.divide_fault = (v.operation == OpPoint) && (sum[3] == 0);
    r.saturated = clip;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vtx_out_t exp_v;
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) matrix_regs[i] = RegReset[i];
      vertex_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (done_o) begin
        if (vertex_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = vertex_q.pop_front();
          if (result_o !== exp_v) begin
            fail_count_o <= fail_count_o + 1;
            if (result_o.out_x !== exp_v.out_x)
              $error("out_x exp %h got %h", exp_v.out_x, result_o.out_x);
            if (result_o.out_y !== exp_v.out_y)
              $error("out_y exp %h got %h", exp_v.out_y, result_o.out_y);
            if (result_o.out_z !== exp_v.out_z)
              $error("out_z exp %h got %h", exp_v.out_z, result_o.out_z);
            if (result_o.out_w !== exp_v.out_w)
              $error("out_w exp %h got %h", exp_v.out_w, result_o.out_w);
            if (result_o.divide_fault !== exp_v.divide_fault)
              $error("divide_fault exp %b got %b", exp_v.divide_fault,
                     result_o.divide_fault);
            if (result_o.saturated !== exp_v.saturated)
              $error("saturated exp %b got %b", exp_v.saturated, result_o.saturated);
          end
        end
      end
      if (start_i && !busy_o) vertex_q.push_back(transform_vertex(item_i));
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NumRegs)
        matrix_regs[cfg_index_i] = cfg_data_i;
      pending_o <= vertex_q.size();
    end
  end

endmodule

### sim/vertex_transform_4x4_tb.sv
`timescale 1ns / 100ps

module vertex_transform_4x4_tb;
  import vtx_pkg::*;

  typedef enum int {
    Row0Left, Row0Right, Row1Left, Row1Right,
    Row2Left, Row2Right, Row3Left, Row3Right
  } mat_reg_e;

  localparam int CycleLimit = 400000;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  vtx_in_t           item_i;
  logic              busy_o;
  logic              done_o;
  vtx_out_t          result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [RegW-1:0]   cfg_data_i;
  int                fail_count;
  int                pending;
  int                cycles;
  logic              idle_on;
  logic [RegW-1:0]   mat [NumRegs];

  vertex_transform_4x4 dut (.*);

  vertex_transform_4x4_chk chk (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .done_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // writes all eight matrix registers from mat; valid stays high across back-to-back words
  task automatic load_matrix();
    for (int i = Row0Left; i <= Row3Right; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i  <= mat[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_vertex(input logic op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w);
    start_i <= 1'b1;
    item_i  <= '{operation: op, in_x: x, in_y: y, in_z: z, in_w: w};
    do @(posedge clk_i); while (busy_o);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0, 1:    return 32'($urandom_range(0, 32'h7_ffff)) - 32'h4_0000;
      2:       return $urandom();
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(input int kind);
    case (kind)
      0:       return 32'($urandom_range(0, 32'h3_ffff)) - 32'h2_0000;
      1:       return $urandom();
      default: return $urandom_range(0, 3) == 0 ? $urandom() : 32'h0;
    endcase
  endfunction

  task automatic random_vertices(input int n);
    for (int i = 0; i < n; i++)
      send_vertex(logic'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord());
  endtask

  initial begin
    rst_ni = 1'b0; start_i = 1'b0; item_i = '0; idle_on = 1'b1;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity from reset: extremes through both operations
    send_vertex(OpHomog, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
    send_vertex(OpHomog, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
    send_vertex(OpHomog, 32'h0, 32'h0, 32'h0, 32'h0);
    send_vertex(OpPoint, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h0);
    send_vertex(OpPoint, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    drain();

    // all-max coefficients: sums clip
    foreach (mat[i]) mat[i] = 64'h7fff_ffff_7fff_ffff;
    load_matrix();
    send_vertex(OpHomog, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(OpHomog, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(OpPoint, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_vertex(OpPoint, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    drain();

    // w column all zero: every point op faults; small divisor clips quotients
    foreach (mat[i]) mat[i] = 64'h0001_0000_0001_0000;
    mat[Row0Right] = 64'h0001_0000_0000_0000;
    mat[Row1Right] = 64'h0001_0000_0000_0000;
    mat[Row2Right] = 64'h0001_0000_0000_0000;
    mat[Row3Right] = 64'h0001_0000_0000_0000;
    load_matrix();
    send_vertex(OpPoint, 32'h0002_0000, 32'h0003_0000, 32'h0, 32'h1234_5678);
    send_vertex(OpPoint, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    send_vertex(OpHomog, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    drain();
    mat[Row3Right] = 64'h0001_0000_0000_0001;
    load_matrix();
    send_vertex(OpPoint, 32'h0100_0000, 32'h0, 32'h0, 32'h0);
    send_vertex(OpPoint, 32'hff00_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    drain();

    // out-of-range index is dropped
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgIdxW'($urandom_range(NumRegs, 255));
    cfg_data_i  <= {$urandom(), $urandom()};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    send_vertex(OpPoint, 32'h0001_8000, 32'h0002_0000, 32'h0003_0000, 32'h0);
    drain();

    // random phases: small, full and sparse matrices, then all-ones, min and reset
    for (int ph = 0; ph < 9; ph++) begin
      foreach (mat[i]) begin
        case (ph)
          6:       mat[i] = '1;
          7:       mat[i] = 64'h8000_0000_8000_0000;
          8:       mat[i] = RegReset[i];
          default: mat[i] = {rand_coef(ph % 3), rand_coef(ph % 3)};
        endcase
      end
      load_matrix();
      idle_on = (ph < 7);
      random_vertices(80);
      if (ph == 2) begin
        // hold off mid-stream until the pipeline is empty
        start_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      random_vertices(80);
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
hw/rtl/vtx_pkg.sv
hw/rtl/vtx_mat_mul.sv
hw/rtl/vtx_div_pipe.sv
hw/rtl/vertex_transform_4x4.sv
sim/vertex_transform_4x4_chk.sv
sim/vertex_transform_4x4_tb.sv
